FILE: design/jfp_pkg.sv
// shared types and constants of the joystick frame parser
package jfp_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned AXIS_W = 16;
  localparam int unsigned CFG_IDX_W = 8;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_HEADER = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FOOTER = CFG_IDX_W'(1);

  localparam logic [BYTE_W-1:0] HEADER_RESET = 8'd170;
  localparam logic [BYTE_W-1:0] FOOTER_RESET = 8'd85;

  // payload bytes that feed the result
  localparam int unsigned USED_BYTES = 5;
  localparam int unsigned AXES = 4;
  localparam int unsigned BTN_SLOT = 4;

  // button codes carried by payload byte five
  localparam logic [BYTE_W-1:0] BTN_ONE = 8'd1;
  localparam logic [BYTE_W-1:0] BTN_TWO = 8'd2;
  localparam logic [BYTE_W-1:0] BTN_THREE = 8'd3;
  localparam logic [BYTE_W-1:0] BTN_FOUR = 8'd4;

  // axis = (b - 100) * 16384 / 100, magnitude by reciprocal: m * ceil(2^26/25) >> 14
  localparam logic [BYTE_W-1:0] AXIS_CENTER = 8'd100;
  localparam int unsigned RECIP_W = 22;
  localparam logic [RECIP_W-1:0] AXIS_RECIP = 22'd2684355;
  localparam int unsigned AXIS_SHIFT = 14;
  localparam int unsigned PROD_W = BYTE_W + RECIP_W;

  typedef struct packed {
    logic signed [AXIS_W-1:0] axis_right_vertical;
    logic signed [AXIS_W-1:0] axis_right_horizontal;
    logic signed [AXIS_W-1:0] axis_left_vertical;
    logic signed [AXIS_W-1:0] axis_left_horizontal;
    logic                     button_code_one;
    logic                     button_code_two;
    logic                     button_code_three;
    logic                     button_code_four;
  } joy_result_t;

endpackage

FILE: design/jfp_cfg_if.sv
// configuration write channel
interface jfp_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [jfp_pkg::CFG_IDX_W-1:0]      index;
  logic [jfp_pkg::BYTE_W-1:0]         data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: design/jfp_byte_if.sv
// received byte channel
interface jfp_byte_if;
  logic                       valid;
  logic                       ready;
  logic [jfp_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

FILE: design/jfp_joy_if.sv
// decoded joystick result channel
interface jfp_joy_if;
  logic                              valid;
  logic                              ready;
  logic signed [jfp_pkg::AXIS_W-1:0] axis_right_vertical;
  logic signed [jfp_pkg::AXIS_W-1:0] axis_right_horizontal;
  logic signed [jfp_pkg::AXIS_W-1:0] axis_left_vertical;
  logic signed [jfp_pkg::AXIS_W-1:0] axis_left_horizontal;
  logic                              button_code_one;
  logic                              button_code_two;
  logic                              button_code_three;
  logic                              button_code_four;

  modport source (
    output valid, input ready,
    output axis_right_vertical, output axis_right_horizontal,
    output axis_left_vertical, output axis_left_horizontal,
    output button_code_one, output button_code_two,
    output button_code_three, output button_code_four
  );
  modport sink (
    input valid, output ready,
    input axis_right_vertical, input axis_right_horizontal,
    input axis_left_vertical, input axis_left_horizontal,
    input button_code_one, input button_code_two,
    input button_code_three, input button_code_four
  );
endinterface

FILE: design/jfp_axis_scale.sv
// maps one payload byte from 0..200 onto signed q1.14, truncated toward zero
module jfp_axis_scale (
  input  logic [jfp_pkg::BYTE_W-1:0]        byte_i,
  output logic signed [jfp_pkg::AXIS_W-1:0] axis_o
);

  logic                          below;
  logic [jfp_pkg::BYTE_W-1:0]    mag;
  logic [jfp_pkg::PROD_W-1:0]    prod;
  logic [jfp_pkg::AXIS_W-1:0]    quot;

  always_comb begin
    below = byte_i < jfp_pkg::AXIS_CENTER;
    mag   = below ? (jfp_pkg::AXIS_CENTER - byte_i) : (byte_i - jfp_pkg::AXIS_CENTER);
    prod  = jfp_pkg::PROD_W'(mag) * jfp_pkg::PROD_W'(jfp_pkg::AXIS_RECIP);
    quot  = prod[jfp_pkg::AXIS_SHIFT +: jfp_pkg::AXIS_W];
    axis_o = below ? -$signed(quot) : $signed(quot);
  end

endmodule

FILE: design/joystick_frame_parser.sv
// joystick frame parser top level
//
// byte_i takes one received serial byte per beat; a beat can be taken in
// every cycle but a stalled footer slot. A frame is a header byte,
// PAYLOAD_BYTES payload bytes and a footer byte; a header counts only
// right after a footer value byte. When the footer slot holds the footer
// value, joy_o carries one result (four q1.14 axes and four button flags)
// in the cycle after that byte. A bad footer drops the frame silently and
// hunting restarts. Throughput: one byte per cycle, set by the single
// position counter and the result register that follows the four axis
// multipliers. If joy_o is stalled, byte_i keeps taking bytes until the
// next footer slot; only that byte waits for the pending result to leave.
// cfg_i writes header_value (index 0) and footer_value (index 1) at any
// time and is always ready; other indexes are dropped.
// Reset: hunting for a header, previous byte zero, header 170, footer 85,
// no result pending.
module joystick_frame_parser #(
  parameter int unsigned PAYLOAD_BYTES = 5
) (
  input logic      clk_i,
  input logic      rst_ni,
  jfp_cfg_if.sink  cfg_i,
  jfp_byte_if.sink byte_i,
  jfp_joy_if.source joy_o
);

  localparam int unsigned POS_W = $clog2(PAYLOAD_BYTES + 2);
  localparam logic [POS_W-1:0] POS_HUNT = POS_W'(0);
  localparam logic [POS_W-1:0] POS_FOOTER = POS_W'(PAYLOAD_BYTES + 1);

  logic [jfp_pkg::BYTE_W-1:0] header_q, footer_q;
  logic [jfp_pkg::BYTE_W-1:0] last_q;
  logic [POS_W-1:0]           pos_q, pos_d;
  logic [jfp_pkg::BYTE_W-1:0] store_q [jfp_pkg::USED_BYTES];
  logic                       res_valid_q, res_valid_d;
  jfp_pkg::joy_result_t       res_q, res_d;
  logic signed [jfp_pkg::AXIS_W-1:0] axis [jfp_pkg::AXES];

  logic accept;
  logic footer_slot;
  logic good_frame;
  logic [jfp_pkg::BYTE_W-1:0] rx;

  assign rx          = byte_i.rx_byte;
  assign footer_slot = pos_q == POS_FOOTER;
  assign byte_i.ready = !(res_valid_q && footer_slot);
  assign accept      = byte_i.valid && byte_i.ready;
  assign good_frame  = accept && footer_slot && (rx == footer_q);
  assign cfg_i.ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q <= jfp_pkg::HEADER_RESET;
      footer_q <= jfp_pkg::FOOTER_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        jfp_pkg::REG_HEADER: header_q <= cfg_i.data;
        jfp_pkg::REG_FOOTER: footer_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // frame position
  always_comb begin
    pos_d = pos_q;
    if (accept) begin
      if (pos_q == POS_HUNT) begin
        if (rx == header_q && last_q == footer_q) begin
          pos_d = POS_W'(1);
        end
      end else if (pos_q <= POS_W'(PAYLOAD_BYTES)) begin
        pos_d = pos_q + POS_W'(1);
      end else begin
        pos_d = POS_HUNT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= POS_HUNT;
      last_q <= '0;
    end else if (accept) begin
      pos_q  <= pos_d;
      last_q <= rx;
    end
  end

  // payload bytes that feed the result
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < jfp_pkg::USED_BYTES; i++) begin
      if (accept && pos_q == POS_W'(i + 1)) begin
        store_q[i] <= rx;
      end
    end
  end

  for (genvar g = 0; g < jfp_pkg::AXES; g++) begin : g_axis
    jfp_axis_scale u_scale (
      .byte_i (store_q[g]),
      .axis_o (axis[g])
    );
  end

  always_comb begin
    res_d = res_q;
    if (good_frame) begin
      res_d.axis_right_vertical   = axis[0];
      res_d.axis_right_horizontal = axis[1];
      res_d.axis_left_vertical    = axis[2];
      res_d.axis_left_horizontal  = axis[3];
      res_d.button_code_one   = store_q[jfp_pkg::BTN_SLOT] == jfp_pkg::BTN_ONE;
      res_d.button_code_two   = store_q[jfp_pkg::BTN_SLOT] == jfp_pkg::BTN_TWO;
      res_d.button_code_three = store_q[jfp_pkg::BTN_SLOT] == jfp_pkg::BTN_THREE;
      res_d.button_code_four  = store_q[jfp_pkg::BTN_SLOT] == jfp_pkg::BTN_FOUR;
    end
    res_valid_d = res_valid_q;
    if (good_frame) begin
      res_valid_d = 1'b1;
    end else if (joy_o.ready) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign joy_o.valid                 = res_valid_q;
  assign joy_o.axis_right_vertical   = res_q.axis_right_vertical;
  assign joy_o.axis_right_horizontal = res_q.axis_right_horizontal;
  assign joy_o.axis_left_vertical    = res_q.axis_left_vertical;
  assign joy_o.axis_left_horizontal  = res_q.axis_left_horizontal;
  assign joy_o.button_code_one       = res_q.button_code_one;
  assign joy_o.button_code_two       = res_q.button_code_two;
  assign joy_o.button_code_three     = res_q.button_code_three;
  assign joy_o.button_code_four      = res_q.button_code_four;

endmodule
